### hw/rtl/mssc_pkg.sv
// ============================================================================
// mssc_pkg: shared constants
// Sizes, event kinds and derived widths for the shadow stack checker.
// ============================================================================
`default_nettype none
package mssc_pkg;
   localparam int NumSources = 12;
   localparam int StackDepth = 1024;
   localparam int FifoDepth  = 64;
   localparam int AddrBits   = 62;

   localparam int SrcW   = 4;
   localparam int LevelW = $clog2(StackDepth + 1);
   localparam int SptrW  = $clog2(StackDepth);
   localparam int HeadW  = $clog2(FifoDepth);
   localparam int FillW  = $clog2(FifoDepth + 1);
   localparam int QaddrW = $clog2(NumSources * FifoDepth);
   localparam int EntryW = AddrBits + 2;

   localparam logic [1:0] KindRet0   = 2'd0;
   localparam logic [1:0] KindCall   = 2'd1;
   localparam logic [1:0] KindSwitch = 2'd2;
   localparam logic [1:0] KindRet3   = 2'd3;
endpackage
`default_nettype wire

### hw/rtl/mssc_ram.sv
// ============================================================================
// mssc_ram: generic single-port RAM
// One write or one read per cycle, read data registered.
// ============================================================================
`default_nettype none
module mssc_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wr_data,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

### hw/rtl/multi_source_shadow_stack_checker.sv
// ============================================================================
// multi_source_shadow_stack_checker: shadow stack return-address checker
// Checks calls and returns from several sources, queueing off-source words.
// ============================================================================
// Channel | Dir | Ports
// req     | in  | req_valid, req_stall, req_source, req_kind, req_address
// rsp     | out | rsp_valid, rsp_stall, rsp_* result fields
//
// A word from a non-current source is written into its FIFO at the accepting
// edge and answered from S_DONE. A call from the current source also answers
// from S_DONE, since the stack write happens at the accepting edge. A return
// reads the stack memory at the accepting edge, compares in S_POP and answers
// from S_DONE. A switch walks queued words through S_FREAD and S_FDATA, with a
// queued return also passing S_POP; the walk answers once it finds an empty FIFO.
// Reset is synchronous and clears levels, fills and heads; the memories need
// no clearing. A stalled result holds in the output register and the next
// word waits until it is taken.
`default_nettype none
module multi_source_shadow_stack_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [3:0]                     req_source,
   input  wire logic [1:0]                     req_kind,
   input  wire logic [61:0]                    req_address,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [7:0]                          rsp_mismatch_count,
   output logic [61:0]                         rsp_first_expected,
   output logic [61:0]                         rsp_first_actual,
   output logic                                rsp_was_queued,
   output logic                                rsp_stack_overflow,
   output logic                                rsp_fifo_overflow,
   output logic                                rsp_bad_target,
   output logic [3:0]                          rsp_current_source
);
   typedef enum logic [2:0] {
      S_IDLE, S_POP, S_FREAD, S_FDATA, S_DONE
   } state_type;

   localparam int SW = mssc_pkg::SrcW;
   localparam int LW = mssc_pkg::LevelW;
   localparam int PW = mssc_pkg::SptrW;
   localparam int HW = mssc_pkg::HeadW;
   localparam int FW = mssc_pkg::FillW;
   localparam int QW = mssc_pkg::QaddrW;
   localparam int EW = mssc_pkg::EntryW;
   localparam int AW = mssc_pkg::AddrBits;
   localparam int NS = mssc_pkg::NumSources;

   state_type state_ff;
   logic [LW-1:0] level_ff;
   logic [SW-1:0] active_ff;
   logic [HW-1:0] head_ff [NS];
   logic [FW-1:0] fill_ff [NS];
   logic [SW-1:0] q_ff;
   logic          drain_ff;        // pop belongs to a drain walk
   logic [AW-1:0] act_ff;          // address compared by a pending pop
   logic          popempty_ff;     // pop found an empty stack

   // stack memory port
   logic          st_we;
   logic [PW-1:0] st_addr;
   logic [AW-1:0] st_wdata, st_rdata;
   // queue memory port
   logic          q_we;
   logic [QW-1:0] q_addr;
   logic [EW-1:0] q_wdata, q_rdata;

   mssc_ram #(.Width(AW), .Depth(mssc_pkg::StackDepth)) u_stack (
      .clock(clock), .wr_en(st_we), .addr(st_addr), .wr_data(st_wdata),
      .rd_data(st_rdata));
   mssc_ram #(.Width(EW), .Depth(NS * mssc_pkg::FifoDepth)) u_queue (
      .clock(clock), .wr_en(q_we), .addr(q_addr), .wr_data(q_wdata),
      .rd_data(q_rdata));

   wire logic accept = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE) || (rsp_valid && rsp_stall);

   wire logic in_range  = req_source < SW'(NS);
   wire logic is_active = req_source == active_ff;
   wire logic [SW-1:0] rs = in_range ? req_source : '0;
   wire logic fifo_full = fill_ff[rs] == FW'(mssc_pkg::FifoDepth);
   wire logic [HW-1:0] slot = HW'(head_ff[rs] + HW'(fill_ff[rs]));

   // Drain entry decode.
   wire logic [1:0]    e_kind = q_rdata[1:0];
   wire logic [AW-1:0] e_addr = q_rdata[EW-1:2];
   wire logic [SW-1:0] qs     = (q_ff < SW'(NS)) ? q_ff : '0;

   wire logic [SW-1:0] sw_tgt = SW'(req_address);
   wire logic sw_ok  = req_address < AW'(NS);
   wire logic e_sw_ok = e_addr < AW'(NS);

   always_comb begin
      st_we    = 1'b0;
      st_addr  = PW'(level_ff);
      st_wdata = req_address;
      q_we     = 1'b0;
      q_addr   = QW'(QW'(rs) * QW'(mssc_pkg::FifoDepth) + QW'(slot));
      q_wdata  = {req_address, req_kind};
      unique case (state_ff)
         S_IDLE: begin
            if (accept && is_active && req_kind == mssc_pkg::KindCall) begin
               st_we = level_ff != LW'(mssc_pkg::StackDepth);
            end else if (accept && is_active && req_kind != mssc_pkg::KindSwitch) begin
               st_addr = PW'(level_ff - LW'(1));
            end else if (accept && !is_active && in_range) begin
               q_we = !fifo_full;
            end
         end
         S_FREAD: begin
            q_addr = QW'(QW'(qs) * QW'(mssc_pkg::FifoDepth) + QW'(head_ff[qs]));
         end
         S_FDATA: begin
            st_wdata = e_addr;
            if (e_kind == mssc_pkg::KindCall) begin
               st_we = level_ff != LW'(mssc_pkg::StackDepth);
            end else begin
               st_addr = PW'(level_ff - LW'(1));
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         level_ff  <= '0;
         active_ff <= '0;
         q_ff      <= '0;
         drain_ff  <= 1'b0;
         rsp_valid <= 1'b0;
         for (int i = 0; i < NS; i++) begin
            head_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_valid <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  rsp_mismatch_count <= '0;
                  rsp_first_expected <= '0;
                  rsp_first_actual   <= '0;
                  rsp_was_queued     <= 1'b0;
                  rsp_stack_overflow <= 1'b0;
                  rsp_fifo_overflow  <= 1'b0;
                  rsp_bad_target     <= 1'b0;
                  drain_ff           <= 1'b0;
                  if (is_active) begin
                     unique case (req_kind)
                        mssc_pkg::KindCall: begin
                           if (level_ff == LW'(mssc_pkg::StackDepth)) begin
                              rsp_stack_overflow <= 1'b1;
                           end else begin
                              level_ff <= level_ff + LW'(1);
                           end
                           state_ff <= S_DONE;
                        end
                        mssc_pkg::KindSwitch: begin
                           if (sw_ok) begin
                              active_ff <= sw_tgt;
                              q_ff      <= sw_tgt;
                           end else begin
                              rsp_bad_target <= 1'b1;
                              q_ff           <= active_ff;
                           end
                           state_ff <= S_FREAD;
                        end
                        mssc_pkg::KindRet0, mssc_pkg::KindRet3: begin
                           act_ff      <= req_address;
                           popempty_ff <= level_ff == '0;
                           if (level_ff != '0) begin
                              level_ff <= level_ff - LW'(1);
                           end
                           state_ff <= S_POP;
                        end
                        default: ;
                     endcase
                  end else begin
                     if (in_range) begin
                        if (fifo_full) begin
                           rsp_fifo_overflow <= 1'b1;
                        end else begin
                           fill_ff[rs]    <= fill_ff[rs] + FW'(1);
                           rsp_was_queued <= 1'b1;
                        end
                     end
                     state_ff <= S_DONE;
                  end
               end
            end
            S_POP: begin
               if ((popempty_ff ? AW'(0) : st_rdata) != act_ff) begin
                  if (rsp_mismatch_count == '0) begin
                     rsp_first_expected <= popempty_ff ? AW'(0) : st_rdata;
                     rsp_first_actual   <= act_ff;
                  end
                  if (rsp_mismatch_count != 8'hff) begin
                     rsp_mismatch_count <= rsp_mismatch_count + 8'd1;
                  end
               end
               state_ff <= drain_ff ? S_FREAD : S_DONE;
            end
            S_FREAD: begin
               if (fill_ff[qs] == '0) begin
                  state_ff <= S_DONE;
               end else begin
                  head_ff[qs] <= head_ff[qs] + HW'(1);
                  fill_ff[qs] <= fill_ff[qs] - FW'(1);
                  state_ff    <= S_FDATA;
               end
            end
            S_FDATA: begin
               drain_ff <= 1'b1;
               unique case (e_kind)
                  mssc_pkg::KindSwitch: begin
                     if (e_sw_ok) begin
                        active_ff <= SW'(e_addr);
                        q_ff      <= SW'(e_addr);
                     end else begin
                        rsp_bad_target <= 1'b1;
                     end
                     state_ff <= S_FREAD;
                  end
                  mssc_pkg::KindCall: begin
                     if (level_ff == LW'(mssc_pkg::StackDepth)) begin
                        rsp_stack_overflow <= 1'b1;
                     end else begin
                        level_ff <= level_ff + LW'(1);
                     end
                     state_ff <= S_FREAD;
                  end
                  mssc_pkg::KindRet0, mssc_pkg::KindRet3: begin
                     act_ff      <= e_addr;
                     popempty_ff <= level_ff == '0;
                     if (level_ff != '0) begin
                        level_ff <= level_ff - LW'(1);
                     end
                     state_ff <= S_POP;
                  end
                  default: ;
               endcase
            end
            S_DONE: begin
               rsp_valid          <= 1'b1;
               rsp_current_source <= active_ff;
               state_ff           <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

### hw/rtl/mssc_checker.sv
// ============================================================================
// mssc_checker: port-level checks for the shadow stack checker
// Watches handshakes and result flags on the top-level ports.
// ============================================================================
`default_nettype none
module mssc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_mismatch_count,
   input wire logic       rsp_was_queued,
   input wire logic       rsp_fifo_overflow,
   input wire logic [3:0] rsp_current_source
);
   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   // A queued word never also reports an overflow or a failed check.
   a_queued_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_queued |-> !rsp_fifo_overflow && rsp_mismatch_count == 8'd0)
      else $error("queued word reports other effects");

   // The current source stays in range.
   a_src_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_current_source < 4'(mssc_pkg::NumSources))
      else $error("current source out of range");

   // A request is never taken in the cycle after one was taken.
   a_seq: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word taken back to back");
endmodule

bind multi_source_shadow_stack_checker mssc_checker u_mssc_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_mismatch_count(rsp_mismatch_count), .rsp_was_queued(rsp_was_queued),
   .rsp_fifo_overflow(rsp_fifo_overflow), .rsp_current_source(rsp_current_source));
`default_nettype wire
